// ===== rtl/kst_pkg.sv =====
package kst_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RES_FULL,
    RES_INS,
    RES_REM,
    RES_HIT,
    RES_MISS,
    RES_READ
  } res_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_SCAN,
    S_LK_RD,
    S_LK_CMP,
    S_RD_OUT
  } state_e;

  typedef struct packed {
    logic        [1:0]  action;
    logic signed [31:0] key;
    logic signed [31:0] rid;
    logic        [3:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [31:0] rid_out;
    logic signed [31:0] key_out;
    logic        [3:0]  slot_out;
    logic               full_res;
    logic        [15:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic cap;
    logic idx_clr;
    logic idx_inc;
    logic rd_idx;
    logic rd_slot;
    logic ins_wr;
    logic rem;
    logic load;
    res_e res;
  } kst_cmd_t;

  typedef struct packed {
    action_e act;
    logic    full;
    logic    vbit;
    logic    last;
    logic    match;
    logic    out_free;
  } kst_sts_t;

endpackage

// ===== rtl/kst_ctrl.sv =====
module kst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kst_pkg::kst_sts_t sts_i,
  output kst_pkg::kst_cmd_t cmd_o
);

  kst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kst_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.res  = kst_pkg::RES_FULL;
    in_ready_o = 1'b0;
    case (state_q)
      kst_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap     = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = kst_pkg::S_DISPATCH;
        end
      end
      kst_pkg::S_DISPATCH: begin
        case (sts_i.act)
          kst_pkg::ACT_INSERT: begin
            if (!sts_i.full) begin
              state_d = kst_pkg::S_INS_SCAN;
            end else if (sts_i.out_free) begin
              cmd_o.load = 1'b1;
              cmd_o.res  = kst_pkg::RES_FULL;
              state_d    = kst_pkg::S_IDLE;
            end
          end
          kst_pkg::ACT_REMOVE: begin
            if (sts_i.out_free) begin
              cmd_o.rem  = 1'b1;
              cmd_o.load = 1'b1;
              cmd_o.res  = kst_pkg::RES_REM;
              state_d    = kst_pkg::S_IDLE;
            end
          end
          kst_pkg::ACT_LOOKUP: begin
            state_d = kst_pkg::S_LK_RD;
          end
          default: begin
            cmd_o.rd_slot = 1'b1;
            state_d       = kst_pkg::S_RD_OUT;
          end
        endcase
      end
      kst_pkg::S_INS_SCAN: begin
        if (sts_i.vbit) begin
          cmd_o.idx_inc = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.ins_wr = 1'b1;
          cmd_o.load   = 1'b1;
          cmd_o.res    = kst_pkg::RES_INS;
          state_d      = kst_pkg::S_IDLE;
        end
      end
      kst_pkg::S_LK_RD: begin
        if (sts_i.vbit) begin
          cmd_o.rd_idx = 1'b1;
          state_d      = kst_pkg::S_LK_CMP;
        end else if (!sts_i.last) begin
          cmd_o.idx_inc = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.res  = kst_pkg::RES_MISS;
          state_d    = kst_pkg::S_IDLE;
        end
      end
      kst_pkg::S_LK_CMP: begin
        if (sts_i.match) begin
          if (sts_i.out_free) begin
            cmd_o.load = 1'b1;
            cmd_o.res  = kst_pkg::RES_HIT;
            state_d    = kst_pkg::S_IDLE;
          end
        end else if (!sts_i.last) begin
          cmd_o.idx_inc = 1'b1;
          state_d       = kst_pkg::S_LK_RD;
        end else if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.res  = kst_pkg::RES_MISS;
          state_d    = kst_pkg::S_IDLE;
        end
      end
      kst_pkg::S_RD_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          cmd_o.res  = kst_pkg::RES_READ;
          state_d    = kst_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/kst_dp.sv =====
module kst_dp #(
  parameter int N_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kst_pkg::in_item_t  in_data_i,
  input  kst_pkg::kst_cmd_t  cmd_i,
  output kst_pkg::kst_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kst_pkg::out_item_t out_data_o
);

  localparam int IDX_W = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;

  kst_pkg::in_item_t  item_q;
  logic [IDX_W-1:0]   idx_q;
  logic [N_SLOTS-1:0] valid_q, valid_d;
  logic [63:0]        mem [N_SLOTS];
  logic [63:0]        rd_q;
  logic               out_valid_q;
  kst_pkg::out_item_t out_q, out_d;
  logic [IDX_W-1:0]   slot_idx;
  logic               slot_ok;
  logic               slot_vbit;

  assign slot_idx  = IDX_W'(item_q.slot);
  assign slot_ok   = (32'(item_q.slot) < N_SLOTS);
  assign slot_vbit = slot_ok && valid_q[slot_idx];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      item_q <= in_data_i;
    end
    if (cmd_i.ins_wr) begin
      mem[idx_q] <= {item_q.key, item_q.rid};
    end
    if (cmd_i.rd_idx) begin
      rd_q <= mem[idx_q];
    end else if (cmd_i.rd_slot && slot_ok) begin
      rd_q <= mem[slot_idx];
    end
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
      valid_q <= valid_d;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.ins_wr) begin
      valid_d[idx_q] = 1'b1;
    end
    if (cmd_i.rem && slot_ok) begin
      valid_d[slot_idx] = 1'b0;
    end
  end

  always_comb begin
    out_d           = '0;
    out_d.status    = kst_pkg::ST_OK;
    out_d.full_res  = &valid_d;
    out_d.occupancy = 16'(valid_d);
    case (cmd_i.res)
      kst_pkg::RES_FULL: begin
        out_d.status = kst_pkg::ST_FULL;
      end
      kst_pkg::RES_INS: begin
        out_d.slot_out = 4'(idx_q);
      end
      kst_pkg::RES_REM: begin
        out_d.status   = slot_vbit ? kst_pkg::ST_OK : kst_pkg::ST_MISS;
        out_d.slot_out = item_q.slot;
      end
      kst_pkg::RES_HIT: begin
        out_d.key_out  = rd_q[63:32];
        out_d.rid_out  = rd_q[31:0];
        out_d.slot_out = 4'(idx_q);
      end
      kst_pkg::RES_MISS: begin
        out_d.status  = kst_pkg::ST_MISS;
        out_d.rid_out = '1;
      end
      kst_pkg::RES_READ: begin
        out_d.status   = slot_vbit ? kst_pkg::ST_OK : kst_pkg::ST_MISS;
        out_d.slot_out = item_q.slot;
        if (slot_ok) begin
          out_d.key_out = rd_q[63:32];
          out_d.rid_out = rd_q[31:0];
        end
      end
      default: begin
        out_d.status = kst_pkg::ST_MISS;
      end
    endcase
  end

  always_comb begin
    sts_o          = '0;
    sts_o.act      = kst_pkg::action_e'(item_q.action);
    sts_o.full     = &valid_q;
    sts_o.vbit     = valid_q[idx_q];
    sts_o.last     = (idx_q == IDX_W'(N_SLOTS - 1));
    sts_o.match    = (rd_q[63:32] == item_q.key);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/keyed_slot_table_top.sv =====
// Insert scans up from slot 0 to the lowest free slot; remove and a full insert
// answer from dispatch; read fetches its slot first; lookup walks the slots until a
// match, skipping empty ones and reading then comparing occupied ones (one read port).
// One item at a time: the next input is taken the cycle after its result is registered.
// Reset clears the occupancy map and the control state at once; slot contents
// stay undefined until written and get no clearing pass.
module keyed_slot_table_top #(
  parameter int N_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kst_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kst_pkg::out_item_t out_data_o
);

  kst_pkg::kst_cmd_t cmd;
  kst_pkg::kst_sts_t sts;

  kst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kst_dp #(
    .N_SLOTS (N_SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/kst_checker.sv =====
module kst_checker #(
  parameter int N_SLOTS = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input kst_pkg::out_item_t out_data_o
);

  localparam logic [63:0] ALL_SLOTS = {64{1'b1}} >> (64 - N_SLOTS);
  localparam logic [15:0] FULL_OCC  = ALL_SLOTS[15:0];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status != 2'd3)
    else $error("undefined status code");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.full_res |-> out_data_o.occupancy == FULL_OCC)
    else $error("full flag disagrees with occupancy");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == kst_pkg::ST_FULL |-> out_data_o.full_res)
    else $error("insert dropped while table not full");

endmodule

bind keyed_slot_table_top kst_checker #(.N_SLOTS(N_SLOTS)) u_kst_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int NUM_SLOTS = 16;
  localparam int RANDOM_ITEMS = 1350;
  localparam int NUM_PHASES = 8;
  localparam int TAIL_CYCLES = 2 * NUM_SLOTS + 16;

  class slot_table_mirror;
    logic signed [31:0] slot_keys [NUM_SLOTS];
    logic signed [31:0] slot_rids [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] occ = '0;
    logic [NUM_SLOTS-1:0] written = '0;
    kst_pkg::out_item_t expected_results[$];
    int errors = 0;

    function void note_transfer(kst_pkg::in_item_t it);
      kst_pkg::out_item_t r;
      bit found;
      r = '0;
      found = 1'b0;
      case (it.action)
        kst_pkg::ACT_INSERT: begin
          if (&occ) begin
            r.status = kst_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
              if (!found && !occ[i]) begin
                found = 1'b1;
                slot_keys[i] = it.key;
                slot_rids[i] = it.rid;
                occ[i] = 1'b1;
                written[i] = 1'b1;
                r.slot_out = 4'(i);
              end
            end
            r.status = kst_pkg::ST_OK;
          end
        end
        kst_pkg::ACT_REMOVE: begin
          r.slot_out = it.slot;
          if (occ[it.slot]) begin
            occ[it.slot] = 1'b0;
            r.status = kst_pkg::ST_OK;
          end else begin
            r.status = kst_pkg::ST_MISS;
          end
        end
        kst_pkg::ACT_LOOKUP: begin
          r.status = kst_pkg::ST_MISS;
          r.rid_out = '1;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!found && occ[i] && slot_keys[i] == it.key) begin
              found = 1'b1;
              r.status = kst_pkg::ST_OK;
              r.rid_out = slot_rids[i];
              r.key_out = slot_keys[i];
              r.slot_out = 4'(i);
            end
          end
        end
        default: begin
          r.slot_out = it.slot;
          r.status = occ[it.slot] ? kst_pkg::ST_OK : kst_pkg::ST_MISS;
          r.rid_out = slot_rids[it.slot];
          r.key_out = slot_keys[it.slot];
        end
      endcase
      r.full_res = &occ;
      r.occupancy = occ;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (act_val !== exp_val) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(kst_pkg::out_item_t got);
      kst_pkg::out_item_t exp_item;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, got);
        errors++;
        return;
      end
      exp_item = expected_results.pop_front();
      compare_field("status", 32'(exp_item.status), 32'(got.status));
      compare_field("rid_out", exp_item.rid_out, got.rid_out);
      compare_field("key_out", exp_item.key_out, got.key_out);
      compare_field("slot_out", 32'(exp_item.slot_out), 32'(got.slot_out));
      compare_field("full_res", 32'(exp_item.full_res), 32'(got.full_res));
      compare_field("occupancy", 32'(exp_item.occupancy), 32'(got.occupancy));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  kst_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  kst_pkg::out_item_t out_data_o;

  slot_table_mirror table_mirror;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  keyed_slot_table_top #(
    .N_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      table_mirror.check_result(out_data_o);
    end
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic kst_pkg::in_item_t make_item(kst_pkg::action_e act, logic [31:0] key,
                                                  logic [31:0] rid, logic [3:0] slot);
    kst_pkg::in_item_t it;
    it.action = act;
    it.key = key;
    it.rid = rid;
    it.slot = slot;
    return it;
  endfunction

  // Starts at a random position so that every set bit can be chosen.
  function automatic logic [3:0] pick_set_bit(logic [NUM_SLOTS-1:0] mask);
    int start;
    int idx;
    start = $urandom_range(NUM_SLOTS - 1);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      idx = (start + i) % NUM_SLOTS;
      if (mask[idx]) begin
        return 4'(idx);
      end
    end
    return 4'(start);
  endfunction

  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4: return 32'h0000_0001;
      5: return 32'h0000_002a;
      default: return $urandom();
    endcase
  endfunction

  function automatic kst_pkg::in_item_t random_item(int insert_pct);
    kst_pkg::in_item_t it;
    int roll;
    it = make_item(kst_pkg::ACT_INSERT, pick_key(), $urandom(),
                   4'($urandom_range(NUM_SLOTS - 1)));
    if ($urandom_range(99) >= insert_pct) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        it.action = kst_pkg::ACT_REMOVE;
        if (|table_mirror.occ && $urandom_range(9) < 7) begin
          it.slot = pick_set_bit(table_mirror.occ);
        end
      end else if (roll < 70) begin
        it.action = kst_pkg::ACT_LOOKUP;
        if (|table_mirror.occ && $urandom_range(1) == 1) begin
          it.key = table_mirror.slot_keys[pick_set_bit(table_mirror.occ)];
        end
      end else if (|table_mirror.written) begin
        it.action = kst_pkg::ACT_READ;
        it.slot = pick_set_bit(table_mirror.written);
      end
    end
    return it;
  endfunction

  task automatic send_item(kst_pkg::in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    table_mirror.note_transfer(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (table_mirror.expected_results.size() != 0);
  endtask

  initial begin
    int insert_pct;
    table_mirror = new;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(make_item(kst_pkg::ACT_INSERT, 32'h8000_0000, 32'h7fff_ffff, 4'd0));
    send_item(make_item(kst_pkg::ACT_INSERT, 32'h7fff_ffff, 32'h8000_0000, 4'd15));
    send_item(make_item(kst_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0000, 4'd0));
    send_item(make_item(kst_pkg::ACT_INSERT, 32'hffff_ffff, 32'hffff_ffff, 4'd15));
    send_item(make_item(kst_pkg::ACT_LOOKUP, 32'h7fff_ffff, 32'h0, 4'd0));
    send_item(make_item(kst_pkg::ACT_LOOKUP, 32'h0001_2345, 32'h0, 4'd0));
    send_item(make_item(kst_pkg::ACT_READ, 32'h0, 32'h0, 4'd0));
    send_item(make_item(kst_pkg::ACT_REMOVE, 32'h0, 32'h0, 4'd1));
    send_item(make_item(kst_pkg::ACT_REMOVE, 32'h0, 32'h0, 4'd1));
    send_item(make_item(kst_pkg::ACT_READ, 32'h0, 32'h0, 4'd1));
    send_item(make_item(kst_pkg::ACT_INSERT, 32'hffff_ffff, 32'h0000_0007, 4'd0));
    send_item(make_item(kst_pkg::ACT_LOOKUP, 32'hffff_ffff, 32'h0, 4'd0));
    send_item(make_item(kst_pkg::ACT_REMOVE, 32'h0, 32'h0, 4'd15));
    for (int i = 0; i < 12; i++) begin
      send_item(make_item(kst_pkg::ACT_INSERT, 32'h100 + i, $urandom(), 4'd0));
    end
    send_item(make_item(kst_pkg::ACT_INSERT, 32'h5555_aaaa, 32'haaaa_5555, 4'd0));
    send_item(make_item(kst_pkg::ACT_READ, 32'h0, 32'h0, 4'd15));
    wait_drained();

    insert_pct = 50;
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
        default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES + 1; n++) begin
        // Swing the insert rate so the table moves between empty and full.
        if (n % 40 == 0) begin
          insert_pct = $urandom_range(15, 85);
        end
        send_item(random_item(insert_pct));
      end
      wait_drained();
    end

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (table_mirror.errors == 0 && table_mirror.expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/kst_pkg.sv
rtl/kst_ctrl.sv
rtl/kst_dp.sv
rtl/keyed_slot_table_top.sv
rtl/kst_checker.sv
sim/tb.sv
